/* hw/rtl/kzc_pkg.sv */
// Shared types, register codes and the sine table generator for the
// kick zone check pipeline. No dependencies.
package kzc_pkg;

  localparam int unsigned KZC_SINE_BITS = 10;
  localparam int unsigned KZC_CFG_IDX_W = 3;
  localparam int unsigned KZC_CFG_DATA_W = 16;
  localparam logic [14:0] KZC_ONE_Q14 = 15'd16384;
  localparam longint unsigned KZC_TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [KZC_CFG_IDX_W-1:0] {
    REG_X_MIN           = 3'd0,
    REG_X_MAX           = 3'd1,
    REG_Y_TOLERANCE     = 3'd2,
    REG_Y_FOOT_OFFSET   = 3'd3,
    REG_ANGLE_OFFSET    = 3'd4,
    REG_ANGLE_TOLERANCE = 3'd5
  } kzc_reg_t;

  typedef struct packed {
    logic signed [15:0] x_min;
    logic signed [15:0] x_max;
    logic        [14:0] y_tolerance;
    logic signed [15:0] y_foot_offset;
    logic signed [15:0] angle_offset;
    logic        [15:0] angle_tolerance;
  } kzc_cfg_t;

  // Per-stage load strobes of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } kzc_adv_t;

  // Quarter-wave sine entry r (Q14) for a table of 2^bits steps per turn.
  // Odd Taylor series to x^15 in Q30 radians.
  function automatic logic [14:0] kzc_sin_entry(int unsigned r, int unsigned bits);
    longint unsigned x;
    longint unsigned t;
    longint          sum;
    longint unsigned rnd;
    x   = (64'(r) * KZC_TWO_PI_Q30) >> bits;
    t   = x;
    sum = longint'(x);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd6;    sum = sum - longint'(t);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd20;   sum = sum + longint'(t);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd42;   sum = sum - longint'(t);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd72;   sum = sum + longint'(t);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd110;  sum = sum - longint'(t);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd156;  sum = sum + longint'(t);
    t = (((t * x) >> 30) * x) >> 30;  t = t / 64'd210;  sum = sum - longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    rnd = (longint'(unsigned'(sum)) + 64'd32768) >> 16;
    return rnd[14:0];
  endfunction

endpackage

/* hw/rtl/kzc_front.sv */
// Stage 1: ball offset, heading table index with quadrant folding, and
// relative kick angle. Uses kzc_pkg.
module kzc_front #(
  parameter int unsigned SINE_TABLE_BITS = kzc_pkg::KZC_SINE_BITS
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [15:0]         ball_x,
  input  logic signed [15:0]         ball_y,
  input  logic signed [15:0]         player_x,
  input  logic signed [15:0]         player_y,
  input  logic signed [15:0]         player_heading,
  input  logic signed [15:0]         kick_direction,
  output logic signed [16:0]         dx_r,
  output logic signed [16:0]         dy_r,
  output logic signed [15:0]         la_r,
  output logic [SINE_TABLE_BITS-2:0] s_addr_r,
  output logic [SINE_TABLE_BITS-2:0] c_addr_r,
  output logic                       s_neg_r,
  output logic                       c_neg_r
);
  import kzc_pkg::*;

  localparam int unsigned B  = SINE_TABLE_BITS;
  localparam int unsigned AW = B - 1;
  localparam logic [AW-1:0] QUARTER = AW'(1 << (B - 2));

  logic [16:0]         hd_rnd;
  logic [B-1:0]        idx;
  logic [1:0]          quad;
  logic [AW-1:0]       r_fwd;
  logic [AW-1:0]       r_rev;
  logic signed [16:0]  dx_nxt;
  logic signed [16:0]  dy_nxt;
  logic signed [15:0]  la_nxt;

  always_comb begin
    // round heading to nearest table step, wrap to one turn
    hd_rnd = {1'b0, player_heading} + 17'(1 << (15 - B));
    idx    = hd_rnd[16-B +: B];
    quad   = idx[B-1 -: 2];
    r_fwd  = AW'(idx[B-3:0]);
    r_rev  = QUARTER - r_fwd;
    dx_nxt = 17'(ball_x) - 17'(player_x);
    dy_nxt = 17'(ball_y) - 17'(player_y);
    la_nxt = kick_direction - player_heading;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      la_r     <= la_nxt;
      s_addr_r <= quad[0] ? r_rev : r_fwd;
      c_addr_r <= quad[0] ? r_fwd : r_rev;
      s_neg_r  <= quad[1];
      c_neg_r  <= quad[1] ^ quad[0];
    end
  end

endmodule

/* hw/rtl/kzc_sine_rom.sv */
// Stage 2: dual-read quarter-wave sine ROM with registered, signed output.
// Table built at elaboration from kzc_pkg::kzc_sin_entry.
module kzc_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = kzc_pkg::KZC_SINE_BITS
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [SINE_TABLE_BITS-2:0] s_addr,
  input  logic [SINE_TABLE_BITS-2:0] c_addr,
  input  logic                       s_neg,
  input  logic                       c_neg,
  input  logic signed [16:0]         dx,
  input  logic signed [16:0]         dy,
  input  logic signed [15:0]         la,
  output logic signed [15:0]         sin_r,
  output logic signed [15:0]         cos_r,
  output logic signed [16:0]         dx_r,
  output logic signed [16:0]         dy_r,
  output logic signed [15:0]         la_r
);
  import kzc_pkg::*;

  localparam int unsigned B = SINE_TABLE_BITS;
  localparam int unsigned Q = 1 << (B - 2);

  logic [14:0]        qtab [0:Q];
  logic signed [15:0] s_mag;
  logic signed [15:0] c_mag;

  for (genvar g = 0; g < Q; g++) begin : g_tab
    assign qtab[g] = kzc_sin_entry(g, B);
  end
  assign qtab[Q] = KZC_ONE_Q14;

  always_comb begin
    s_mag = {1'b0, qtab[s_addr]};
    c_mag = {1'b0, qtab[c_addr]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= s_neg ? -s_mag : s_mag;
      cos_r <= c_neg ? -c_mag : c_mag;
      dx_r  <= dx;
      dy_r  <= dy;
      la_r  <= la;
    end
  end

endmodule

/* hw/rtl/kzc_rotate.sv */
// Stages 3 and 4: rotation products, then sum, round half up and saturate.
// Uses kzc_pkg.
module kzc_rotate (
  input  logic               clk,
  input  logic               en_mul,
  input  logic               en_sum,
  input  logic signed [15:0] sin_v,
  input  logic signed [15:0] cos_v,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  input  logic signed [15:0] la,
  output logic signed [15:0] lx_r,
  output logic signed [15:0] ly_r,
  output logic signed [15:0] la_r
);
  import kzc_pkg::*;

  logic signed [32:0] dxc_r, dys_r, dyc_r, dxs_r;
  logic signed [15:0] la_m_r;
  logic signed [33:0] sum_x, sum_y;
  logic signed [19:0] qx, qy;

  function automatic logic signed [15:0] sat16(logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en_mul) begin
      dxc_r  <= 33'(dx * cos_v);
      dys_r  <= 33'(dy * sin_v);
      dyc_r  <= 33'(dy * cos_v);
      dxs_r  <= 33'(dx * sin_v);
      la_m_r <= la;
    end
  end

  always_comb begin
    sum_x = 34'(dxc_r) + 34'(dys_r) + 34'sd8192;
    sum_y = 34'(dyc_r) - 34'(dxs_r) + 34'sd8192;
    qx    = sum_x[33:14];
    qy    = sum_y[33:14];
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      lx_r <= sat16(qx);
      ly_r <= sat16(qy);
      la_r <= la_m_r;
    end
  end

endmodule

/* hw/rtl/kzc_zone.sv */
// Stage 5: left and right foot zone tests and the output register.
// Uses kzc_pkg for the configuration struct.
module kzc_zone (
  input  logic               clk,
  input  logic               en,
  input  kzc_pkg::kzc_cfg_t  cfg,
  input  logic signed [15:0] lx,
  input  logic signed [15:0] ly,
  input  logic signed [15:0] la,
  output logic               kickable_r,
  output logic               left_ok_r,
  output logic               right_ok_r,
  output logic signed [15:0] lx_r,
  output logic signed [15:0] ly_r,
  output logic signed [15:0] la_r
);
  import kzc_pkg::*;

  logic signed [17:0] ly18, yoff18, ytol18, atol18;
  logic signed [17:0] dy_l, dy_r, el18, er18;
  logic signed [15:0] el, er;
  logic               x_ok, lok, rok;

  always_comb begin
    ly18   = 18'(ly);
    yoff18 = 18'(cfg.y_foot_offset);
    ytol18 = {3'b000, cfg.y_tolerance};
    atol18 = {2'b00, cfg.angle_tolerance};
    dy_l   = ly18 - yoff18;
    dy_r   = ly18 + yoff18;
    // angle errors wrap at half turn
    el     = la + cfg.angle_offset;
    er     = la - cfg.angle_offset;
    el18   = 18'(el);
    er18   = 18'(er);
    x_ok   = (lx > cfg.x_min) && (lx < cfg.x_max);
    lok    = x_ok && (dy_l > -ytol18) && (dy_l < ytol18)
             && (el18 > -atol18) && (el18 < atol18);
    rok    = x_ok && (dy_r > -ytol18) && (dy_r < ytol18)
             && (er18 > -atol18) && (er18 < atol18);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kickable_r <= lok | rok;
      left_ok_r  <= lok;
      right_ok_r <= rok;
      lx_r       <= lx;
      ly_r       <= ly;
      la_r       <= la;
    end
  end

endmodule

/* hw/rtl/kick_zone_check_unit.sv */
// Top level of the kick zone check pipeline: config registers, stage
// valid bits and flow control. Uses kzc_pkg and all kzc_* stage modules.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: ball and player
//   world positions, player heading and wished kick direction.
//   Output channel (out_valid / out_stall) returns one result per request:
//   kickable, left_ok, right_ok and the ball position and kick angle in the
//   player frame, in request order.
//   One request is taken every cycle while in_stall is low; the five stages
//   are offset, table read, multiply, round and saturate, and zone compare.
//   A stalled receiver holds the output register; the stages behind it keep
//   filling bubbles, so in_stall rises only when all five stages are full.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults. Write cfg_* only while the pipeline is empty.
//   Register indexes beyond the list are ignored.
module kick_zone_check_unit #(
  parameter int unsigned SINE_TABLE_BITS = kzc_pkg::KZC_SINE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kzc_pkg::KZC_CFG_IDX_W-1:0]   cfg_index,
  input  logic [kzc_pkg::KZC_CFG_DATA_W-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_ball_x,
  input  logic signed [15:0]                  in_ball_y,
  input  logic signed [15:0]                  in_player_x,
  input  logic signed [15:0]                  in_player_y,
  input  logic signed [15:0]                  in_player_heading,
  input  logic signed [15:0]                  in_kick_direction,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kickable,
  output logic                                out_left_ok,
  output logic                                out_right_ok,
  output logic signed [15:0]                  out_local_x,
  output logic signed [15:0]                  out_local_y,
  output logic signed [15:0]                  out_local_angle
);
  import kzc_pkg::*;

  localparam int unsigned AW = SINE_TABLE_BITS - 1;

  kzc_cfg_t cfg_r, cfg_nxt;
  kzc_adv_t adv;
  logic [4:0] vld_r, vld_nxt;
  logic [4:0] rdy;

  logic signed [16:0] s1_dx, s1_dy, s2_dx, s2_dy;
  logic signed [15:0] s1_la, s2_la, s4_la;
  logic [AW-1:0]      s1_s_addr, s1_c_addr;
  logic               s1_s_neg, s1_c_neg;
  logic signed [15:0] s2_sin, s2_cos, s4_lx, s4_ly;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_X_MIN:           cfg_nxt.x_min           = cfg_data;
        REG_X_MAX:           cfg_nxt.x_max           = cfg_data;
        REG_Y_TOLERANCE:     cfg_nxt.y_tolerance     = cfg_data[14:0];
        REG_Y_FOOT_OFFSET:   cfg_nxt.y_foot_offset   = cfg_data;
        REG_ANGLE_OFFSET:    cfg_nxt.angle_offset    = cfg_data;
        REG_ANGLE_TOLERANCE: cfg_nxt.angle_tolerance = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min           <= 16'sd123;
      cfg_r.x_max           <= 16'sd225;
      cfg_r.y_tolerance     <= 15'd41;
      cfg_r.y_foot_offset   <= 16'sd82;
      cfg_r.angle_offset    <= 16'sd0;
      cfg_r.angle_tolerance <= 16'd1820;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // flow control: a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[4] = !vld_r[4] || !out_stall;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    adv.s1 = rdy[0];
    adv.s2 = rdy[1];
    adv.s3 = rdy[2];
    adv.s4 = rdy[3];
    adv.s5 = rdy[4];
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[4];

  kzc_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
    .clk            (clk),
    .en             (adv.s1),
    .ball_x         (in_ball_x),
    .ball_y         (in_ball_y),
    .player_x       (in_player_x),
    .player_y       (in_player_y),
    .player_heading (in_player_heading),
    .kick_direction (in_kick_direction),
    .dx_r           (s1_dx),
    .dy_r           (s1_dy),
    .la_r           (s1_la),
    .s_addr_r       (s1_s_addr),
    .c_addr_r       (s1_c_addr),
    .s_neg_r        (s1_s_neg),
    .c_neg_r        (s1_c_neg)
  );

  kzc_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .clk    (clk),
    .en     (adv.s2),
    .s_addr (s1_s_addr),
    .c_addr (s1_c_addr),
    .s_neg  (s1_s_neg),
    .c_neg  (s1_c_neg),
    .dx     (s1_dx),
    .dy     (s1_dy),
    .la     (s1_la),
    .sin_r  (s2_sin),
    .cos_r  (s2_cos),
    .dx_r   (s2_dx),
    .dy_r   (s2_dy),
    .la_r   (s2_la)
  );

  kzc_rotate u_rotate (
    .clk    (clk),
    .en_mul (adv.s3),
    .en_sum (adv.s4),
    .sin_v  (s2_sin),
    .cos_v  (s2_cos),
    .dx     (s2_dx),
    .dy     (s2_dy),
    .la     (s2_la),
    .lx_r   (s4_lx),
    .ly_r   (s4_ly),
    .la_r   (s4_la)
  );

  kzc_zone u_zone (
    .clk        (clk),
    .en         (adv.s5),
    .cfg        (cfg_r),
    .lx         (s4_lx),
    .ly         (s4_ly),
    .la         (s4_la),
    .kickable_r (out_kickable),
    .left_ok_r  (out_left_ok),
    .right_ok_r (out_right_ok),
    .lx_r       (out_local_x),
    .ly_r       (out_local_y),
    .la_r       (out_local_angle)
  );

  // stall back-pressure only with a full pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ($countones(vld_r) == 5))
    else $error("input stalled with an empty stage");

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_local_x)
      && $stable(out_local_y) && $stable(out_local_angle)
      && $stable(out_kickable))
    else $error("stalled result changed");

  a_kick_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kickable == (out_left_ok || out_right_ok)))
    else $error("kickable differs from foot results");

  // an accepted request reaches the output when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("request lost in pipeline");

endmodule

/* tb/tb.sv */
// Self-checking testbench for kick_zone_check_unit: random and directed pose requests,
// each result checked against an in-bench predictor. Depends on kzc_pkg.
`timescale 1ns / 100ps

module tb;
  import kzc_pkg::*;

  localparam int unsigned SINE_BITS = KZC_SINE_BITS;
  localparam int unsigned SINE_STEPS = 1 << SINE_BITS;
  localparam int unsigned SINE_QTR = SINE_STEPS / 4;
  localparam int HALF_STEP = 1 << (15 - SINE_BITS);
  localparam longint unsigned ANG_2PI_Q30 = 64'd6746518852;
  localparam int unsigned NUM_REGS = REG_ANGLE_TOLERANCE + 1;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 168;

  typedef struct {
    logic signed [15:0] ball_x;
    logic signed [15:0] ball_y;
    logic signed [15:0] player_x;
    logic signed [15:0] player_y;
    logic signed [15:0] heading;
    logic signed [15:0] kick_angle;
  } pose_req_t;

  typedef struct {
    logic               kickable;
    logic               left_ok;
    logic               right_ok;
    logic signed [15:0] local_x;
    logic signed [15:0] local_y;
    logic signed [15:0] local_angle;
  } zone_res_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [KZC_CFG_IDX_W-1:0]   cfg_index;
  logic [KZC_CFG_DATA_W-1:0]  cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [15:0]         in_ball_x;
  logic signed [15:0]         in_ball_y;
  logic signed [15:0]         in_player_x;
  logic signed [15:0]         in_player_y;
  logic signed [15:0]         in_player_heading;
  logic signed [15:0]         in_kick_direction;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_kickable;
  logic                       out_left_ok;
  logic                       out_right_ok;
  logic signed [15:0]         out_local_x;
  logic signed [15:0]         out_local_y;
  logic signed [15:0]         out_local_angle;

  kick_zone_check_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ball_x        (in_ball_x),
    .in_ball_y        (in_ball_y),
    .in_player_x      (in_player_x),
    .in_player_y      (in_player_y),
    .in_player_heading(in_player_heading),
    .in_kick_direction(in_kick_direction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kickable     (out_kickable),
    .out_left_ok      (out_left_ok),
    .out_right_ok     (out_right_ok),
    .out_local_x      (out_local_x),
    .out_local_y      (out_local_y),
    .out_local_angle  (out_local_angle)
  );

  int          sin_quarter [0:SINE_QTR];
  kzc_cfg_t    zone_cfg;
  zone_res_t   zone_expect_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned burst_left = 0;
  bit          steady_send = 1'b0;
  int unsigned hold_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int sin_quarter_entry(int unsigned r);
    longint unsigned rr, ang, term;
    longint          acc;
    rr   = r;
    ang  = (rr * ANG_2PI_Q30) >> SINE_BITS;
    term = ang;
    acc  = longint'(ang);
    for (int k = 1; k <= 7; k++) begin
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((acc + 32768) >> 16);
  endfunction

  function automatic int sine_at(int idx);
    int unsigned i, quad, r;
    i    = idx & (SINE_STEPS - 1);
    quad = i >> (SINE_BITS - 2);
    r    = i & (SINE_QTR - 1);
    case (quad)
      0:       return sin_quarter[r];
      1:       return sin_quarter[SINE_QTR - r];
      2:       return -sin_quarter[r];
      default: return -sin_quarter[SINE_QTR - r];
    endcase
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return int'(v);
  endfunction

  // round half up to Q0, then saturate
  function automatic int round_q14(longint v);
    return clamp16((v + 8192) >>> 14);
  endfunction

  function automatic logic foot_fits(int lx, int ly, int yoff, logic signed [15:0] err);
    int d, ad, ae;
    d  = ly - yoff;
    ad = (d < 0) ? -d : d;
    ae = (err < 0) ? -int'(err) : int'(err);
    return (lx > $signed(zone_cfg.x_min)) && (lx < $signed(zone_cfg.x_max)) &&
           (ad < int'(zone_cfg.y_tolerance)) && (ae < int'(zone_cfg.angle_tolerance));
  endfunction

  function automatic zone_res_t predict_zone(pose_req_t q);
    zone_res_t          r;
    logic [15:0]        hd;
    int                 idx, s, c, lx, ly, yoff;
    longint             dx, dy;
    logic signed [15:0] la, el, er;
    hd   = q.heading;
    idx  = (int'(hd) + HALF_STEP) >> (16 - SINE_BITS);
    s    = sine_at(idx);
    c    = sine_at(idx + SINE_QTR);
    dx   = longint'(q.ball_x) - longint'(q.player_x);
    dy   = longint'(q.ball_y) - longint'(q.player_y);
    lx   = round_q14(dx * c + dy * s);
    ly   = round_q14(dy * c - dx * s);
    la   = q.kick_angle - q.heading;
    el   = la + $signed(zone_cfg.angle_offset);
    er   = la - $signed(zone_cfg.angle_offset);
    yoff = $signed(zone_cfg.y_foot_offset);
    r.left_ok     = foot_fits(lx, ly, yoff, el);
    r.right_ok    = foot_fits(lx, ly, -yoff, er);
    r.kickable    = r.left_ok | r.right_ok;
    r.local_x     = 16'(lx);
    r.local_y     = 16'(ly);
    r.local_angle = la;
    return r;
  endfunction

  // ---------------------------------------------------------------- requests

  function automatic pose_req_t mk_req(int bx, int by, int px, int py, int hd, int kd);
    pose_req_t q;
    q.ball_x     = 16'(bx);
    q.ball_y     = 16'(by);
    q.player_x   = 16'(px);
    q.player_y   = 16'(py);
    q.heading    = 16'(hd);
    q.kick_angle = 16'(kd);
    return q;
  endfunction

  function automatic pose_req_t noise_req();
    return mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Place the ball near one foot zone of the current setting, in world terms.
  function automatic pose_req_t aimed_req();
    pose_req_t          q;
    bit                 right;
    int                 lo, hi, tmp, lx, ly, yoff, ytol, atol, aerr, idx, s, c;
    longint             wx, wy;
    logic [15:0]        hd;
    logic signed [15:0] la_t;
    right = 1'($urandom_range(0, 1));
    lo = $signed(zone_cfg.x_min) - 4;
    hi = $signed(zone_cfg.x_max) + 4;
    if (hi < lo) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    lx   = clamp16(lo + int'($urandom_range(0, hi - lo)));
    yoff = right ? -int'($signed(zone_cfg.y_foot_offset)) : int'($signed(zone_cfg.y_foot_offset));
    ytol = int'(zone_cfg.y_tolerance) + 4;
    ly   = clamp16(yoff - ytol + int'($urandom_range(0, 2 * ytol)));
    q.heading = 16'($urandom);
    hd  = q.heading;
    idx = (int'(hd) + HALF_STEP) >> (16 - SINE_BITS);
    s   = sine_at(idx);
    c   = sine_at(idx + SINE_QTR);
    wx  = (longint'(lx) * c - longint'(ly) * s + 8192) >>> 14;
    wy  = (longint'(lx) * s + longint'(ly) * c + 8192) >>> 14;
    q.player_x = 16'($urandom);
    q.player_y = 16'($urandom);
    if (longint'(q.player_x) + wx > 32767 || longint'(q.player_x) + wx < -32768) begin
      q.player_x = 16'(-(wx / 2));
    end
    if (longint'(q.player_y) + wy > 32767 || longint'(q.player_y) + wy < -32768) begin
      q.player_y = 16'(-(wy / 2));
    end
    q.ball_x = 16'(longint'(q.player_x) + wx);
    q.ball_y = 16'(longint'(q.player_y) + wy);
    atol = int'(zone_cfg.angle_tolerance);
    if (atol > 30000) begin
      atol = 30000;
    end
    aerr = -(atol + 4) + int'($urandom_range(0, 2 * (atol + 4)));
    la_t = right ? $signed(zone_cfg.angle_offset) : -$signed(zone_cfg.angle_offset);
    q.kick_angle = q.heading + la_t + 16'(aerr);
    return q;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_req(pose_req_t q);
    int unsigned gap;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 8);
        end
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_ball_x         <= q.ball_x;
    in_ball_y         <= q.ball_y;
    in_player_x       <= q.player_x;
    in_player_y       <= q.player_y;
    in_player_heading <= q.heading;
    in_kick_direction <= q.kick_angle;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (zone_expect_q.size() == 0);
  endtask

  task automatic write_reg(logic [KZC_CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_X_MIN:           zone_cfg.x_min           = val;
      REG_X_MAX:           zone_cfg.x_max           = val;
      REG_Y_TOLERANCE:     zone_cfg.y_tolerance     = val[14:0];
      REG_Y_FOOT_OFFSET:   zone_cfg.y_foot_offset   = val;
      REG_ANGLE_OFFSET:    zone_cfg.angle_offset    = val;
      REG_ANGLE_TOLERANCE: zone_cfg.angle_tolerance = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_zone(logic [15:0] xmin, logic [15:0] xmax, logic [15:0] ytol,
                          logic [15:0] yoff, logic [15:0] aoff, logic [15:0] atol);
    write_reg(REG_X_MIN, xmin);
    write_reg(REG_X_MAX, xmax);
    write_reg(REG_Y_TOLERANCE, ytol);
    write_reg(REG_Y_FOOT_OFFSET, yoff);
    write_reg(REG_ANGLE_OFFSET, aoff);
    write_reg(REG_ANGLE_TOLERANCE, atol);
  endtask

  task automatic run_items(int unsigned n, int unsigned noise_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_req(noise_req());
      end else begin
        send_req(aimed_req());
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0d, expected %0d",
             result_count, what, got, want);
  endtask

  always @(posedge clk) begin : accept_monitor
    pose_req_t q;
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0) begin
      q = mk_req(in_ball_x, in_ball_y, in_player_x, in_player_y,
                 in_player_heading, in_kick_direction);
      zone_expect_q.push_back(predict_zone(q));
    end
  end

  always @(posedge clk) begin : result_checker
    zone_res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (zone_expect_q.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        want = zone_expect_q.pop_front();
        if (out_kickable !== want.kickable)
          report_mismatch("kickable", int'(out_kickable), int'(want.kickable));
        if (out_left_ok !== want.left_ok)
          report_mismatch("left_ok", int'(out_left_ok), int'(want.left_ok));
        if (out_right_ok !== want.right_ok)
          report_mismatch("right_ok", int'(out_right_ok), int'(want.right_ok));
        if (out_local_x !== want.local_x)
          report_mismatch("local_x", int'(out_local_x), int'(want.local_x));
        if (out_local_y !== want.local_y)
          report_mismatch("local_y", int'(out_local_y), int'(want.local_y));
        if (out_local_angle !== want.local_angle)
          report_mismatch("local_angle", int'(out_local_angle), int'(want.local_angle));
      end
      result_count++;
    end
  end

  // Receiver: switch between stall modes; a requested hold-off takes priority.
  initial begin : receiver_stall
    stall_mode_t mode;
    int unsigned mode_left, n, phase;
    logic [7:0]  pat;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    phase     = 0;
    pat       = '0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
          pat       = 8'($urandom);
        end
        mode_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= pat[phase % 8];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_defaults();
    pose_req_t reqs[$];
    // zone bounds at heading 0, where the rotation is exact
    reqs.push_back(mk_req(170, 82, 0, 0, 0, 0));
    reqs.push_back(mk_req(170, -82, 0, 0, 0, 0));
    reqs.push_back(mk_req(123, 82, 0, 0, 0, 0));
    reqs.push_back(mk_req(124, 82, 0, 0, 0, 0));
    reqs.push_back(mk_req(224, -82, 0, 0, 0, 0));
    reqs.push_back(mk_req(225, -82, 0, 0, 0, 0));
    reqs.push_back(mk_req(170, 41, 0, 0, 0, 0));
    reqs.push_back(mk_req(170, 122, 0, 0, 0, 0));
    reqs.push_back(mk_req(170, 123, 0, 0, 0, 0));
    reqs.push_back(mk_req(170, 82, 0, 0, 0, 1819));
    reqs.push_back(mk_req(170, 82, 0, 0, 0, 1820));
    reqs.push_back(mk_req(170, -82, 0, 0, 0, -1819));
    reqs.push_back(mk_req(170, -82, 0, 0, 0, -1820));
    // half-turn angle error
    reqs.push_back(mk_req(170, 82, 0, 0, 0, -32768));
    // saturation both ways
    reqs.push_back(mk_req(32767, 32767, -32768, -32768, 0, 0));
    reqs.push_back(mk_req(-32768, -32768, 32767, 32767, 16384, 0));
    reqs.push_back(mk_req(32767, -32768, -32768, 32767, -16384, 100));
    // heading rounding to the nearest table step, and angle wrap
    reqs.push_back(mk_req(1000, -500, -20, 40, -32768, 12345));
    reqs.push_back(mk_req(1000, -500, -20, 40, 32767, -12345));
    reqs.push_back(mk_req(1000, -500, -20, 40, HALF_STEP - 1, 0));
    reqs.push_back(mk_req(1000, -500, -20, 40, HALF_STEP, 0));
    reqs.push_back(mk_req(1000, -500, -20, 40, -HALF_STEP - 1, 0));
    reqs.push_back(mk_req(0, 0, 0, 0, -32768, 32767));
    reqs.push_back(mk_req(-32768, 32767, -32768, 32767, 8192, -8192));
    foreach (reqs[i]) begin
      send_req(reqs[i]);
    end
    wait_idle();
  endtask

  task automatic run_extreme(logic [15:0] xmin, logic [15:0] xmax, logic [15:0] ytol,
                             logic [15:0] yoff, logic [15:0] aoff, logic [15:0] atol);
    set_zone(xmin, xmax, ytol, yoff, aoff, atol);
    send_req(mk_req(170, 82, 0, 0, 0, -32768));
    run_items(14, 10);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // widest zone; offsets at -32768 so the negated foot offsets overflow 16 bits
    run_extreme(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    // tolerance above half turn always passes
    run_extreme(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    run_extreme(16'd0, 16'd400, 16'd100, 16'd50, 16'd0, 16'h8001);
    // zero tolerance never passes
    run_extreme(16'd123, 16'd225, 16'd41, 16'd82, 16'd0, 16'd0);
    run_extreme(16'd123, 16'd225, 16'd0, 16'd82, 16'd0, 16'd1820);
    // empty and inverted x ranges
    run_extreme(16'd200, 16'd201, 16'd41, 16'd82, 16'd0, 16'd1820);
    run_extreme(16'h7FFF, 16'h8000, 16'd41, 16'd82, 16'd0, 16'd1820);
  endtask

  task automatic test_ignored_index();
    set_zone(16'd100, 16'd300, 16'd60, 16'hFF9C, 16'd4000, 16'd2500);
    for (int unsigned i = NUM_REGS; i < (1 << KZC_CFG_IDX_W); i++) begin
      write_reg(KZC_CFG_IDX_W'(i), 16'($urandom));
    end
    run_items(20, 10);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_zone(16'd123, 16'd225, 16'd41, 16'd82, 16'd0, 16'd1820);
    steady_send = 1'b1;
    hold_cycles = 80;
    run_items(30, 10);
    hold_cycles = 25;
    run_items(30, 10);
    steady_send = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_zones();
    int xmin;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 5) == 0) begin
        set_zone(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
      end else begin
        xmin = int'($urandom_range(0, 400)) - 100;
        set_zone(16'(xmin), 16'(xmin + int'($urandom_range(2, 400))),
                 16'($urandom_range(1, 150)), 16'(int'($urandom_range(0, 400)) - 200),
                 16'($urandom), 16'($urandom_range(0, 6000)));
      end
      run_items(PHASE_ITEMS, 20);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_ball_x         = '0;
    in_ball_y         = '0;
    in_player_x       = '0;
    in_player_y       = '0;
    in_player_heading = '0;
    in_kick_direction = '0;
    for (int unsigned r = 0; r < SINE_QTR; r++) begin
      sin_quarter[r] = sin_quarter_entry(r);
    end
    sin_quarter[SINE_QTR] = 16384;
    zone_cfg.x_min           = 16'sd123;
    zone_cfg.x_max           = 16'sd225;
    zone_cfg.y_tolerance     = 15'd41;
    zone_cfg.y_foot_offset   = 16'sd82;
    zone_cfg.angle_offset    = 16'sd0;
    zone_cfg.angle_tolerance = 16'd1820;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_ignored_index();
    test_backpressure();
    test_random_zones();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
